// ===== rtl/ist_pkg.sv =====
// ist_pkg: shared types, operation codes and widths for the integer set table.
// Used by ist_cell and integer_set_table; depends on nothing else.
`timescale 1ns / 1ps

package ist_pkg;

   localparam int VALUE_W          = 32;
   localparam int FUNC_W           = 2;
   localparam int SIZE_W           = 5;
   localparam int DEFAULT_CAPACITY = 16;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic        [FUNC_W-1:0]  func_type;
   typedef logic        [SIZE_W-1:0]  size_type;

   // operation codes; the unused code behaves as a query
   localparam func_type FUNC_ADD    = 2'd0;
   localparam func_type FUNC_DELETE = 2'd1;
   localparam func_type FUNC_QUERY  = 2'd2;

   // control broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic compare;   // latch this cell's match against the incoming value
      logic push;      // shift the chain up by one, new value into cell 0
      logic pull;      // cells at and above the hit take their upper neighbor
   } cmd_type;

endpackage

// ===== rtl/integer_set_table.sv =====
// integer_set_table: set of distinct signed 32-bit values in a chain of cells.
// Depends on ist_pkg and ist_cell.
`timescale 1ns / 1ps
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall req_func, req_value
//   rsp_      out        rsp_valid/rsp_stall rsp_was_present, rsp_set_size,
//                                            rsp_rejected_full
//
// In the accept cycle every cell compares its entry with req_value and
// registers a match bit; in the commit state the match bits ripple up the
// cell chain and, once the result register is free, the table commits
// push, pull or nothing, loading the result register. req_stall is high in
// the commit state, so it stays high while a full result register is stalled.
// Reset clears the fill count, the control state, the result valid flag and
// the cells' match flags; cells at or above the fill count are never compared,
// so no clearing pass is needed. A result waiting under rsp_stall does not
// block acceptance of the next transaction, only its commit.

module integer_set_table #(
   parameter int CAPACITY = ist_pkg::DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ist_pkg::func_type  req_func,
   input  ist_pkg::value_type req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_was_present,
   output ist_pkg::size_type  rsp_set_size,
   output logic               rsp_rejected_full
);
   import ist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_COMMIT = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   func_type         func_ff;
   value_type        value_ff;

   logic             rsp_valid_ff;
   logic             was_present_ff;
   size_type         set_size_ff;
   logic             rejected_full_ff;

   cmd_type          cmd;
   logic             accept;
   logic             out_free;
   logic             commit;
   logic             hit;
   logic             full;
   logic             add_op;
   logic             del_op;
   logic [CNT_W+SIZE_W-1:0] count_wide;

   value_type        entry_w  [CAPACITY];
   logic [CAPACITY-1:0] match_w;
   logic [CAPACITY:0]   prefix_w;

   // handshake: hold off new requests while one waits to commit
   assign req_stall = (state_ff == ST_COMMIT);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_COMMIT) && out_free;

   // the top of the match chain says whether any held entry matched
   assign hit    = prefix_w[CAPACITY];
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign add_op = (func_ff == FUNC_ADD);
   assign del_op = (func_ff == FUNC_DELETE);

   assign cmd.compare = accept;
   assign cmd.push    = commit && add_op && !hit && !full;
   assign cmd.pull    = commit && del_op && hit;

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pull) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // zero-extend before taking the low bits of the size field
   assign count_wide = {{SIZE_W{1'b0}}, count_in};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // chain of cells; cell 0 takes the new value on push
   assign prefix_w[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type lower_w;
      value_type upper_w;

      if (i == 0) begin : g_first
         assign lower_w = value_ff;
      end else begin : g_lower
         assign lower_w = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign upper_w = entry_w[i];
      end else begin : g_upper
         assign upper_w = entry_w[i+1];
      end

      ist_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .req_value   (req_value),
         .count       (count_ff),
         .lower_entry (lower_w),
         .upper_entry (upper_w),
         .prefix_in   (prefix_w[i]),
         .entry       (entry_w[i]),
         .match       (match_w[i]),
         .prefix_out  (prefix_w[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (commit) begin
         was_present_ff   <= hit;
         set_size_ff      <= count_wide[SIZE_W-1:0];
         rejected_full_ff <= add_op && !hit && full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_present   = was_present_ff;
   assign rsp_set_size      = set_size_ff;
   assign rsp_rejected_full = rejected_full_ff;

   // values are distinct, so at most one cell can match
   assert property (@(posedge clock) disable iff (reset) $onehot0(match_w))
      else $error("more than one cell matched");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   assert property (@(posedge clock) disable iff (reset) !(cmd.push && cmd.pull))
      else $error("push and pull in the same cycle");

   assert property (@(posedge clock) disable iff (reset) commit |=> !req_stall && rsp_valid)
      else $error("commit did not free the request side or load a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected_full |-> !rsp_was_present)
      else $error("full rejection reported for a present value");

endmodule

// ===== rtl/ist_cell.sv =====
// ist_cell: one slot of the set chain, holding a value and its match flag.
// Depends on ist_pkg.
`timescale 1ns / 1ps

module ist_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  ist_pkg::cmd_type   cmd,
   input  ist_pkg::value_type req_value,
   input  logic [CNT_W-1:0]   count,
   input  ist_pkg::value_type lower_entry,
   input  ist_pkg::value_type upper_entry,
   input  logic               prefix_in,
   output ist_pkg::value_type entry,
   output logic               match,
   output logic               prefix_out
);
   import ist_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      match_ff;
   logic      match_in;
   logic      occupied;

   assign occupied   = CNT_W'(INDEX) < count;
   assign prefix_out = prefix_in | match_ff;

   always_comb begin
      match_in = match_ff;
      if (cmd.compare) begin
         match_in = occupied && (entry_ff == req_value);
      end
   end

   // push shifts up the whole chain, pull closes the gap left by the hit
   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         entry_in = lower_entry;
      end else if (cmd.pull && prefix_out) begin
         entry_in = upper_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== tb/sv/integer_set_table_tb.sv =====
// integer_set_table_tb: self-checking bench for the integer set table, with its own set
// image, a clocked driver fed from a queue of planned operations, and a clocked monitor.
// Depends on ist_pkg and integer_set_table.
`timescale 1ns / 1ps

module integer_set_table_tb;
   import ist_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int POOL_DEPTH  = 24;
   localparam int RANDOM_OPS  = 2000;

   // the spare operation code, expected to behave as a query
   localparam func_type FUNC_SPARE = 2'd3;

   localparam value_type VALUE_MIN = 32'h8000_0000;
   localparam value_type VALUE_MAX = 32'h7fff_ffff;

   // Contents of the set as this bench tracks it: live slots 0 .. fill-1.
   typedef struct packed {
      logic [CAPACITY-1:0][VALUE_W-1:0] slot;
      size_type                         fill;
   } set_image_type;

   typedef struct packed {
      logic     was_present;
      size_type set_size;
      logic     rejected_full;
   } outcome_type;

   typedef struct packed {
      func_type  op;
      value_type value;
      logic      drain_first;  // hold this transaction until nothing is outstanding
      int        gap_after;    // idle cycles to insert after it is accepted
   } planned_op_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   func_type  req_func = FUNC_QUERY;
   value_type req_value = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_was_present;
   size_type  rsp_set_size;
   logic      rsp_rejected_full;

   planned_op_type pending_ops[$];
   outcome_type    expected_outcomes[$];
   set_image_type  model_image = '0;
   set_image_type  plan_image = '0;
   value_type      value_pool[POOL_DEPTH];

   int  issued_ops = 0;
   int  accepted_ops = 0;
   int  checked_results = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;

   integer_set_table #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_was_present  (rsp_was_present),
      .rsp_set_size     (rsp_set_size),
      .rsp_rejected_full(rsp_rejected_full)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one operation to a set image and return the updated image; the
   // outcome that the block must report comes back through res.
   function automatic set_image_type apply_set_op(input set_image_type img,
         input func_type op, input value_type v, output outcome_type res);
      set_image_type nxt;
      int            hit;
      int            i;
      nxt = img;
      hit = -1;
      // only live slots take part in the search
      for (i = 0; i < CAPACITY; i++) begin
         if (hit < 0 && i < img.fill && value_type'(img.slot[i]) == v) begin
            hit = i;
         end
      end
      res.was_present   = (hit >= 0);
      res.rejected_full = 1'b0;
      if (op == FUNC_ADD) begin
         if (hit < 0) begin
            if (img.fill < CAPACITY) begin
               nxt.slot[img.fill] = v;
               nxt.fill           = img.fill + 1'b1;
            end else begin
               res.rejected_full = 1'b1;
            end
         end
      end else if (op == FUNC_DELETE && hit >= 0) begin
         // move the last live entry into the freed slot
         nxt.slot[hit] = img.slot[img.fill - 1];
         nxt.fill      = img.fill - 1'b1;
      end
      // a delete that misses, query and the spare code leave the rest untouched
      res.set_size = nxt.fill;
      return nxt;
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one; none at all
   // while a quiet stretch is being planned.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Queue one operation for the driver and advance the planning image, so
   // later random choices can aim at values that are really held.
   task automatic plan_op(input func_type op, input value_type v, input bit drain);
      planned_op_type item;
      outcome_type    ignored;
      item.op          = op;
      item.value       = v;
      item.drain_first = drain;
      item.gap_after   = pick_gap();
      pending_ops.push_back(item);
      plan_image = apply_set_op(plan_image, op, v, ignored);
   endtask

   // Pick a value: mostly a held one, often one from a small shared pool so
   // that adds collide and deletes hit, sometimes anything at all.
   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55 && plan_image.fill > 0) begin
         return value_type'(plan_image.slot[$urandom_range(0, plan_image.fill - 1)]);
      end else if (r < 90) begin
         return value_pool[$urandom_range(0, POOL_DEPTH - 1)];
      end
      return value_type'($urandom);
   endfunction

   // Plan the stimulus, release reset, then wait for everything to drain.
   initial begin : stimulus
      int        k;
      int        r;
      int        add_weight;
      int        del_weight;
      func_type  op;

      value_pool[0] = VALUE_MIN;
      value_pool[1] = VALUE_MAX;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (k = 4; k < POOL_DEPTH; k++) begin
         value_pool[k] = value_type'($urandom);
      end

      // Directed part: empty table, extremes of the value range, duplicates,
      // the spare code, a delete from the middle of the chain, and a full table.
      plan_op(FUNC_QUERY, '0, 1'b0);
      plan_op(FUNC_DELETE, '0, 1'b0);            // delete on an empty table
      plan_op(FUNC_ADD, VALUE_MIN, 1'b0);
      plan_op(FUNC_ADD, VALUE_MAX, 1'b0);
      plan_op(FUNC_ADD, -1, 1'b0);
      plan_op(FUNC_ADD, '0, 1'b0);
      plan_op(FUNC_ADD, VALUE_MIN, 1'b0);        // already held
      plan_op(FUNC_QUERY, VALUE_MAX, 1'b0);
      plan_op(FUNC_SPARE, -1, 1'b0);             // spare code acts as a query
      plan_op(FUNC_DELETE, -1, 1'b0);            // middle slot, the entries above it move down
      plan_op(FUNC_DELETE, -1, 1'b0);            // now absent
      plan_op(FUNC_QUERY, '0, 1'b0);
      for (k = 0; k < CAPACITY - 3; k++) begin
         plan_op(FUNC_ADD, value_type'(32'd1 << (2 * k + 1)), 1'b0);
      end
      plan_op(FUNC_ADD, 32'sd5, 1'b0);           // absent value on a full table
      plan_op(FUNC_ADD, VALUE_MAX, 1'b0);        // held value on a full table
      plan_op(FUNC_DELETE, VALUE_MIN, 1'b0);     // oldest entry of a full table
      plan_op(FUNC_DELETE, value_pool[0], 1'b0); // same value, gone by now

      // Random part in blocks of 100 that swing the fill level between empty
      // and full; some blocks run without sender gaps, some start drained.
      for (k = 0; k < RANDOM_OPS; k++) begin
         case ((k / 100) % 4)
            0: begin
               add_weight = 70;
               del_weight = 10;
            end
            2: begin
               add_weight = 20;
               del_weight = 55;
            end
            default: begin
               add_weight = 45;
               del_weight = 30;
            end
         endcase
         quiet = ((k / 100) % 5 == 2);
         r = $urandom_range(0, 99);
         if (r < add_weight) begin
            op = FUNC_ADD;
         end else if (r < add_weight + del_weight) begin
            op = FUNC_DELETE;
         end else if (r < 95) begin
            op = FUNC_QUERY;
         end else begin
            op = FUNC_SPARE;
         end
         plan_op(op, pick_value(), (k % 700) == 0);
      end
      quiet = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last transaction to be taken, then for its result.
      while (pending_ops.size() != 0 || accepted_ops != issued_ops) begin
         @(posedge clock);
      end
      while (expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
      // Give a stray extra result a chance to show up.
      repeat (10) @(posedge clock);
      error_count += expected_outcomes.size();
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Driver: inputs change at the falling edge. A transaction stays on the
   // port until the rising edge that accepts it; then insert its gap, hold
   // for a drain if the next one asks for it, or put the next one out.
   always @(negedge clock) begin : drive_req
      planned_op_type item;
      if (!reset && (!req_valid || accepted_ops == issued_ops)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0 &&
               (!pending_ops[0].drain_first || expected_outcomes.size() == 0)) begin
            item = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_func  <= item.op;
            req_value <= item.value;
            gap_left  = item.gap_after;
            issued_ops++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side stall: runs of no stall, short stalls and the odd long one.
   always @(negedge clock) begin : drive_stall
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(0, 20);
         end else if (r < 90) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(8, 40);
         end
      end
   end

   // Monitor: sample both handshakes at the rising edge. Check a result
   // before predicting a transaction taken at the same edge, so a result can
   // only ever match an older transaction.
   always @(posedge clock) begin : monitor
      outcome_type want;
      outcome_type prediction;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results checked",
                  cycle_count, checked_results);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected result: present=%0b size=%0d full=%0b",
                           rsp_was_present, rsp_set_size, rsp_rejected_full);
               end
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_was_present !== want.was_present ||
                     rsp_set_size !== want.set_size ||
                     rsp_rejected_full !== want.rejected_full) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("result %0d: expected present=%0b size=%0d full=%0b, %s",
                              checked_results, want.was_present, want.set_size,
                              want.rejected_full, "got:");
                     $display("   present=%0b size=%0d full=%0b",
                              rsp_was_present, rsp_set_size, rsp_rejected_full);
                  end
               end
               checked_results++;
            end
         end
         if (req_valid && !req_stall) begin
            model_image = apply_set_op(model_image, req_func, req_value, prediction);
            expected_outcomes.push_back(prediction);
            accepted_ops++;
         end
      end
   end

endmodule
